// ----- hw/rtl/iepm_pkg.sv -----
`timescale 1ns / 1ps

package iepm_pkg;

    localparam int PAGE_BYTES_DEF   = 32;
    localparam int POINTER_BITS_DEF = 16;

    localparam int OP_W      = 2;
    localparam int IDX_W     = 5;
    localparam int BYTE_W    = 8;
    localparam int BIT_CNT_W = 4;
    localparam int BYTE_CNT_W = 6;
    localparam int STEP_W    = 9;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 9;

    localparam logic [BYTE_W-1:0] DEVICE_CODE_RST = 8'hA0;
    localparam logic [STEP_W-1:0] PAGE_STEP_RST   = 9'h020;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEVICE_CODE = 1'd0,
        CFG_PAGE_STEP   = 1'd1
    } cfg_reg_t;

    typedef enum logic [OP_W-1:0] {
        OP_TICK  = 2'd0,
        OP_LOAD  = 2'd1,
        OP_WRITE = 2'd2,
        OP_READ  = 2'd3
    } op_t;

    typedef enum logic [3:0] {
        PH_IDLE      = 4'd0,
        PH_START     = 4'd1,
        PH_CTRLW     = 4'd2,
        PH_ACK_CTRLW = 4'd3,
        PH_ADDRH     = 4'd4,
        PH_ACK_ADDRH = 4'd5,
        PH_ADDRL     = 4'd6,
        PH_ACK_ADDRL = 4'd7,
        PH_WDATA     = 4'd8,
        PH_ACK_WDATA = 4'd9,
        PH_RSTART    = 4'd10,
        PH_CTRLR     = 4'd11,
        PH_ACK_CTRLR = 4'd12,
        PH_RDATA     = 4'd13,
        PH_MACK      = 4'd14,
        PH_STOP      = 4'd15
    } phase_t;

    typedef struct packed {
        logic              scl_level;
        logic              sda_level;
        logic              sda_released;
        logic              busy_res;
        logic              read_valid;
        logic [BYTE_W-1:0] read_data;
        logic              read_last;
    } out_word_t;

    function automatic logic [BIT_CNT_W:0] phase_ticks(input phase_t ph);
        logic [BIT_CNT_W:0] n;
        unique case (ph)
            PH_START, PH_RSTART, PH_STOP: n = 5'd3;
            PH_CTRLW, PH_ADDRH, PH_ADDRL, PH_WDATA, PH_CTRLR, PH_RDATA: n = 5'd16;
            default: n = 5'd2;
        endcase
        return n;
    endfunction

endpackage

// ----- hw/rtl/iepm_if.sv -----
`timescale 1ns / 1ps

interface iepm_in_if;
    logic                            valid;
    logic                            ready;
    logic [iepm_pkg::OP_W-1:0]       operation;
    logic [iepm_pkg::IDX_W-1:0]      buffer_index;
    logic [iepm_pkg::BYTE_W-1:0]     load_value;
    logic                            sda_in;

    modport source (output valid, output operation, output buffer_index,
                    output load_value, output sda_in, input ready);
    modport sink (input valid, input operation, input buffer_index,
                  input load_value, input sda_in, output ready);
endinterface

interface iepm_out_if;
    logic                            valid;
    logic                            ready;
    logic                            scl_level;
    logic                            sda_level;
    logic                            sda_released;
    logic                            busy_res;
    logic                            read_valid;
    logic [iepm_pkg::BYTE_W-1:0]     read_data;
    logic                            read_last;

    modport source (output valid, output scl_level, output sda_level,
                    output sda_released, output busy_res, output read_valid,
                    output read_data, output read_last, input ready);
    modport sink (input valid, input scl_level, input sda_level,
                  input sda_released, input busy_res, input read_valid,
                  input read_data, input read_last, output ready);
endinterface

// ----- hw/rtl/iepm_page_buf.sv -----
`timescale 1ns / 1ps

module iepm_page_buf #(
    parameter int DEPTH = iepm_pkg::PAGE_BYTES_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                          clk,
    input  logic                          we,
    input  logic [AW-1:0]                 waddr,
    input  logic [iepm_pkg::BYTE_W-1:0]   wdata,
    input  logic [AW-1:0]                 raddr,
    output logic [iepm_pkg::BYTE_W-1:0]   rdata
);

    logic [iepm_pkg::BYTE_W-1:0] mem [2**AW];
    logic [iepm_pkg::BYTE_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- hw/rtl/i2c_eeprom_page_master.sv -----
`timescale 1ns / 1ps

// Bit-level I2C master for EEPROM page writes and page reads. Every input word is one
// half-bit tick and yields exactly one result word, valid the cycle after the word is
// accepted. The result sits in an output register; a new word is taken in the same cycle
// the previous result leaves, so one word per cycle is sustained while the result side is
// ready, and a result that waits holds off the input. Commands (buffer load, page write,
// page read) are honored only while idle. Buffered page bytes sit in a synchronous RAM
// with one write and one read port; the next data byte is read during the two-tick ack
// slot ahead of it, and the first byte comes from slot zero while the address goes out.
// After the stop, the read or write pointer, whichever the operation used, advances by page_step.
module i2c_eeprom_page_master #(
    parameter int PAGE_BYTES   = iepm_pkg::PAGE_BYTES_DEF,
    parameter int POINTER_BITS = iepm_pkg::POINTER_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [iepm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [iepm_pkg::CFG_DATA_W-1:0]   cfg_data,
    iepm_in_if.sink                           item,
    iepm_out_if.source                        result
);

    localparam int AW = (PAGE_BYTES > 1) ? $clog2(PAGE_BYTES) : 1;
    localparam int EW = ((AW > iepm_pkg::IDX_W) ? AW : iepm_pkg::IDX_W) + 1;
    localparam logic [iepm_pkg::BYTE_CNT_W:0] PAGE_LIM = (iepm_pkg::BYTE_CNT_W + 1)'(PAGE_BYTES);

    logic [iepm_pkg::BYTE_W-1:0]     device_code_reg;
    logic [iepm_pkg::STEP_W-1:0]     page_step_reg;

    iepm_pkg::phase_t                phase_reg, phase_next;
    logic [iepm_pkg::BIT_CNT_W-1:0]  bit_reg, bit_next;
    logic [iepm_pkg::BYTE_CNT_W-1:0] byte_reg, byte_next;
    logic [iepm_pkg::BYTE_W-1:0]     shift_reg, shift_next;
    logic [POINTER_BITS-1:0]         wptr_reg, wptr_next;
    logic [POINTER_BITS-1:0]         rptr_reg, rptr_next;
    logic                            is_read_reg, is_read_next;

    iepm_pkg::out_word_t             out_reg, out_next;
    logic                            out_valid_reg, out_valid_next;

    logic                            fire;
    logic                            mem_we;
    logic [EW-1:0]                   idx_ext;
    logic [AW-1:0]                   mem_raddr;
    logic [iepm_pkg::BYTE_CNT_W-1:0] byte_inc;
    logic [iepm_pkg::BYTE_W-1:0]     mem_rdata;

    assign item.ready = !out_valid_reg || result.ready;
    assign fire       = item.valid && item.ready;
    assign idx_ext    = EW'(item.buffer_index);
    assign byte_inc   = byte_reg + 1'b1;
    assign mem_we     = fire && (phase_reg == iepm_pkg::PH_IDLE)
                        && (item.operation == iepm_pkg::OP_LOAD)
                        && (idx_ext < EW'(PAGE_BYTES));

    // prefetch the next byte to send while in the ack slot
    assign mem_raddr  = (phase_reg == iepm_pkg::PH_ACK_WDATA) ? byte_inc[AW-1:0] : '0;

    iepm_page_buf #(
        .DEPTH (PAGE_BYTES),
        .AW    (AW)
    ) u_page_buf (
        .clk   (clk),
        .we    (mem_we),
        .waddr (idx_ext[AW-1:0]),
        .wdata (item.load_value),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            device_code_reg <= iepm_pkg::DEVICE_CODE_RST;
            page_step_reg   <= iepm_pkg::PAGE_STEP_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                iepm_pkg::CFG_DEVICE_CODE: device_code_reg <= cfg_data[iepm_pkg::BYTE_W-1:0];
                iepm_pkg::CFG_PAGE_STEP:   page_step_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= iepm_pkg::PH_IDLE;
            bit_reg       <= '0;
            byte_reg      <= '0;
            shift_reg     <= '0;
            wptr_reg      <= '0;
            rptr_reg      <= '0;
            is_read_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            bit_reg       <= bit_next;
            byte_reg      <= byte_next;
            shift_reg     <= shift_next;
            wptr_reg      <= wptr_next;
            rptr_reg      <= rptr_next;
            is_read_reg   <= is_read_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_reg <= out_next;
        end
    end

    always_comb
    begin
        iepm_pkg::phase_t                ph;
        logic [iepm_pkg::BIT_CNT_W-1:0]  t;
        logic [iepm_pkg::BYTE_CNT_W-1:0] bc;
        logic [iepm_pkg::BYTE_W-1:0]     sr;
        logic                            rd;
        logic [iepm_pkg::BYTE_CNT_W:0]   bc_plus;
        logic                            last_byte;
        logic [15:0]                     ptr16;
        logic [POINTER_BITS-1:0]         wp;
        logic [POINTER_BITS-1:0]         rp;
        iepm_pkg::phase_t                enter;
        logic                            do_enter;

        ph       = phase_reg;
        t        = bit_reg;
        bc       = byte_reg;
        sr       = shift_reg;
        rd       = is_read_reg;
        wp       = wptr_reg;
        rp       = rptr_reg;
        enter    = iepm_pkg::PH_IDLE;
        do_enter = 1'b0;
        out_next = '{scl_level: 1'b1, sda_level: 1'b1, sda_released: 1'b0,
                     busy_res: 1'b1, read_valid: 1'b0, read_data: '0, read_last: 1'b0};

        if (ph == iepm_pkg::PH_IDLE)
        begin
            case (item.operation) inside
                iepm_pkg::OP_WRITE, iepm_pkg::OP_READ:
                begin
                    rd = (item.operation == iepm_pkg::OP_READ);
                    bc = '0;
                    ph = iepm_pkg::PH_START;
                    t  = '0;
                end
                default: ;
            endcase
        end

        bc_plus   = {1'b0, bc} + 1'b1;
        last_byte = (bc_plus >= PAGE_LIM);

        unique case (ph)
            iepm_pkg::PH_IDLE:
                out_next.busy_res = 1'b0;
            iepm_pkg::PH_START, iepm_pkg::PH_RSTART:
            begin
                out_next.scl_level = (t != 0);
                out_next.sda_level = (t != 2);
            end
            iepm_pkg::PH_STOP:
            begin
                out_next.scl_level = (t != 0);
                out_next.sda_level = (t == 2);
            end
            iepm_pkg::PH_CTRLW, iepm_pkg::PH_ADDRH, iepm_pkg::PH_ADDRL,
            iepm_pkg::PH_WDATA, iepm_pkg::PH_CTRLR:
            begin
                out_next.scl_level = t[0];
                out_next.sda_level = sr[iepm_pkg::BYTE_W-1];
                if (t[0])
                begin
                    sr = {sr[iepm_pkg::BYTE_W-2:0], 1'b0};
                end
            end
            iepm_pkg::PH_RDATA:
            begin
                out_next.scl_level    = t[0];
                out_next.sda_released = 1'b1;
                if (t[0])
                begin
                    sr = {sr[iepm_pkg::BYTE_W-2:0], item.sda_in};
                end
                if (t == '1)
                begin
                    out_next.read_valid = 1'b1;
                    out_next.read_data  = sr;
                    out_next.read_last  = last_byte;
                end
            end
            iepm_pkg::PH_MACK:
            begin
                out_next.scl_level    = t[0];
                out_next.sda_released = last_byte;
                out_next.sda_level    = last_byte;
            end
            default:
            begin
                out_next.scl_level    = t[0];
                out_next.sda_released = 1'b1;
            end
        endcase

        if (ph != iepm_pkg::PH_IDLE)
        begin
            if (({1'b0, t} + 1'b1) < iepm_pkg::phase_ticks(ph))
            begin
                t = t + 1'b1;
            end
            else
            begin
                do_enter = 1'b1;
                unique case (ph)
                    iepm_pkg::PH_START:     enter = iepm_pkg::PH_CTRLW;
                    iepm_pkg::PH_CTRLW:     enter = iepm_pkg::PH_ACK_CTRLW;
                    iepm_pkg::PH_ACK_CTRLW: enter = iepm_pkg::PH_ADDRH;
                    iepm_pkg::PH_ADDRH:     enter = iepm_pkg::PH_ACK_ADDRH;
                    iepm_pkg::PH_ACK_ADDRH: enter = iepm_pkg::PH_ADDRL;
                    iepm_pkg::PH_ADDRL:     enter = iepm_pkg::PH_ACK_ADDRL;
                    iepm_pkg::PH_ACK_ADDRL:
                    begin
                        bc    = '0;
                        enter = rd ? iepm_pkg::PH_RSTART : iepm_pkg::PH_WDATA;
                    end
                    iepm_pkg::PH_WDATA:     enter = iepm_pkg::PH_ACK_WDATA;
                    iepm_pkg::PH_RSTART:    enter = iepm_pkg::PH_CTRLR;
                    iepm_pkg::PH_CTRLR:     enter = iepm_pkg::PH_ACK_CTRLR;
                    iepm_pkg::PH_ACK_CTRLR:
                    begin
                        bc    = '0;
                        enter = iepm_pkg::PH_RDATA;
                    end
                    iepm_pkg::PH_RDATA:     enter = iepm_pkg::PH_MACK;
                    iepm_pkg::PH_ACK_WDATA, iepm_pkg::PH_MACK:
                    begin
                        bc = bc_plus[iepm_pkg::BYTE_CNT_W-1:0];
                        if (last_byte || bc == '0)
                        begin
                            enter = iepm_pkg::PH_STOP;
                        end
                        else if (ph == iepm_pkg::PH_MACK)
                        begin
                            enter = iepm_pkg::PH_RDATA;
                        end
                        else
                        begin
                            enter = iepm_pkg::PH_WDATA;
                        end
                    end
                    iepm_pkg::PH_STOP:
                    begin
                        if (rd)
                        begin
                            rp = rp + POINTER_BITS'(page_step_reg);
                        end
                        else
                        begin
                            wp = wp + POINTER_BITS'(page_step_reg);
                        end
                        bc    = '0;
                        enter = iepm_pkg::PH_IDLE;
                    end
                    default: enter = iepm_pkg::PH_IDLE;
                endcase
            end
        end

        ptr16 = rd ? 16'(rptr_reg) : 16'(wptr_reg);
        if (do_enter)
        begin
            ph = enter;
            t  = '0;
            unique case (enter)
                iepm_pkg::PH_CTRLW: sr = {device_code_reg[iepm_pkg::BYTE_W-1:1], 1'b0};
                iepm_pkg::PH_CTRLR: sr = {device_code_reg[iepm_pkg::BYTE_W-1:1], 1'b1};
                iepm_pkg::PH_ADDRH: sr = ptr16[15:8];
                iepm_pkg::PH_ADDRL: sr = ptr16[7:0];
                iepm_pkg::PH_WDATA: sr = mem_rdata;
                iepm_pkg::PH_RDATA: sr = '0;
                default: ;
            endcase
        end

        phase_next   = phase_reg;
        bit_next     = bit_reg;
        byte_next    = byte_reg;
        shift_next   = shift_reg;
        wptr_next    = wptr_reg;
        rptr_next    = rptr_reg;
        is_read_next = is_read_reg;
        if (fire)
        begin
            phase_next   = ph;
            bit_next     = t;
            byte_next    = bc;
            shift_next   = sr;
            wptr_next    = wp;
            rptr_next    = rp;
            is_read_next = rd;
        end

        if (fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.scl_level    = out_reg.scl_level;
    assign result.sda_level    = out_reg.sda_level;
    assign result.sda_released = out_reg.sda_released;
    assign result.busy_res     = out_reg.busy_res;
    assign result.read_valid   = out_reg.read_valid;
    assign result.read_data    = out_reg.read_data;
    assign result.read_last    = out_reg.read_last;

endmodule
